// ===== hdl/rclc_pkg.sv =====
// Shared types and constants for the rectifier CAN login controller.
package rclc_pkg;

  // Received and transmitted CAN identifiers.
  localparam logic [28:0] ID_LOGIN_REQ     = 29'h05014400;
  localparam logic [28:0] ID_LOGIN         = 29'h05004804;
  localparam logic [28:0] ID_LIMITS_LONG   = 29'h05FF4005;
  localparam logic [28:0] ID_LIMITS_SHORT  = 29'h05FF4004;
  localparam logic [28:0] ID_ANNOUNCE_BASE = 29'h05000000;
  localparam logic [28:0] ID_STAT_NORMAL   = 29'h05014004;
  localparam logic [28:0] ID_STAT_LIMIT    = 29'h05014008;
  localparam logic [28:0] ID_STAT_WALKIN   = 29'h05014010;
  localparam logic [28:0] ID_STAT_LOWIN    = 29'h0501400C;

  // Current limit and message counter limits.
  localparam logic [15:0] CURRENT_MAX     = 16'd500;
  localparam logic [15:0] CURRENT_RESTART = 16'd100;
  localparam logic [7:0]  COUNT_LIMIT     = 8'd40;

  // Configuration register reset values.
  localparam logic [15:0] OUTPUT_VOLTAGE_RESET    = 16'd5750;
  localparam logic [15:0] OVER_VOLTAGE_RESET      = 16'd5950;
  localparam logic        LONG_WALK_IN_RESET      = 1'b1;
  localparam logic [9:0]  CURRENT_INCREMENT_RESET = 10'd100;

  // Configuration register indexes.
  localparam logic [1:0] REG_OUTPUT_VOLTAGE    = 2'd0;
  localparam logic [1:0] REG_OVER_VOLTAGE      = 2'd1;
  localparam logic [1:0] REG_LONG_WALK_IN      = 2'd2;
  localparam logic [1:0] REG_CURRENT_INCREMENT = 2'd3;

  // Default depth of the frame queue between front and back.
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Kind of a frame to transmit.
  typedef enum logic {
    FR_LOGIN,
    FR_LIMITS
  } frame_kind_t;

  // One complete transmit frame as it travels through the queue.
  typedef struct packed {
    logic            last;
    logic [7:0][7:0] data;
    logic [28:0]     id;
  } frame_t;

  // Front status seen by the top level.
  typedef struct packed {
    logic        busy;
    logic        push;
    logic [15:0] current_limit;
  } front_status_t;

  // Queue status shared between queue, front, back and top level.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== hdl/rclc_queue.sv =====
// Small register queue of complete transmit frames.
module rclc_queue
  import rclc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  frame_t        push_data,
  input  logic          pop,
  output frame_t        pop_data,
  output queue_status_t status
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  frame_t        mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = mem[rd_ptr];

  // Storage is written without reset; only pointers and count are cleared.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/rclc_front.sv =====
// Front part: accepts and classifies frames, keeps unit state, queues transmit frames.
module rclc_front
  import rclc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [95:0]   s_tdata,
  input  logic          s_tuser,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  input  queue_status_t q_status,
  output logic          push,
  output frame_t        push_data,
  output front_status_t status
);

  typedef enum logic [1:0] {
    CL_NONE,
    CL_LOGIN_REQ,
    CL_ANNOUNCE,
    CL_STATUS
  } class_t;

  // Configuration registers.
  logic [15:0] output_voltage;
  logic [15:0] over_voltage;
  logic        long_walk_in;
  logic [9:0]  current_increment;

  // Unit state.
  logic [7:0][7:0] unit_serial;
  logic [7:0]      frame_count;
  logic [15:0]     current_limit;

  // Frame plan of the item in progress.
  logic            busy;
  frame_kind_t     plan [3];
  logic [1:0]      plan_len;
  logic [1:0]      plan_idx;

  // Decode of the incoming beat.
  logic [28:0]     in_id;
  logic [7:0][7:0] in_data;
  logic            accept;
  class_t          in_class;
  logic [7:0]      count_inc;
  logic [15:0]     cl_sum;
  logic [15:0]     cl_step;
  logic            force_login;

  logic [7:0][7:0] unit_serial_next;
  logic [7:0]      frame_count_next;
  logic [15:0]     current_limit_next;
  frame_kind_t     plan_next [3];
  logic [1:0]      plan_len_next;

  assign in_id    = s_tdata[28:0];
  assign in_data  = s_tdata[92:29];
  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;

  // Classify the received identifier; a login request wins over an announce match.
  always_comb begin
    if (in_id == ID_LOGIN_REQ) begin
      in_class = CL_LOGIN_REQ;
    end else if (in_id == 29'(ID_ANNOUNCE_BASE + {13'd0, in_data[5], in_data[6]})) begin
      in_class = CL_ANNOUNCE;
    end else if (in_id == ID_STAT_NORMAL || in_id == ID_STAT_LIMIT ||
                 in_id == ID_STAT_WALKIN || in_id == ID_STAT_LOWIN) begin
      in_class = CL_STATUS;
    end else begin
      in_class = CL_NONE;
    end
  end

  // Counter step, current step and the resulting state and plan.
  always_comb begin
    count_inc          = (frame_count == 8'hFF) ? frame_count : frame_count + 8'd1;
    force_login        = (count_inc > COUNT_LIMIT);
    cl_sum             = current_limit + {6'd0, current_increment};
    cl_step            = (cl_sum > CURRENT_MAX) ? CURRENT_RESTART : cl_sum;
    unit_serial_next   = unit_serial;
    frame_count_next   = frame_count;
    current_limit_next = current_limit;
    plan_next[0]       = FR_LOGIN;
    plan_next[1]       = FR_LIMITS;
    plan_next[2]       = FR_LIMITS;
    plan_len_next      = 2'd0;
    unique case (in_class)
      CL_LOGIN_REQ: begin
        unit_serial_next = in_data;
        frame_count_next = count_inc;
        plan_len_next    = 2'd2;
      end
      CL_ANNOUNCE: begin
        unit_serial_next[5:0] = in_data[6:1];
        frame_count_next      = 8'd0;
        plan_len_next         = 2'd2;
      end
      CL_STATUS: begin
        frame_count_next = force_login ? 8'd1 : count_inc;
        if (s_tuser) begin
          current_limit_next = cl_step;
        end
        if (force_login && s_tuser) begin
          plan_next[1]  = FR_LOGIN;
          plan_len_next = 2'd3;
        end else if (force_login) begin
          plan_len_next = 2'd1;
        end else if (s_tuser) begin
          plan_len_next = 2'd2;
        end
      end
      default: begin
        plan_len_next = 2'd0;
      end
    endcase
  end

  // One frame per cycle goes into the queue while it has room.
  assign push = busy && !q_status.full;

  always_comb begin
    push_data.last = (plan_idx == plan_len - 2'd1);
    if (plan[plan_idx] == FR_LOGIN) begin
      push_data.id   = ID_LOGIN;
      push_data.data = unit_serial;
    end else begin
      push_data.id   = long_walk_in ? ID_LIMITS_LONG : ID_LIMITS_SHORT;
      push_data.data = {over_voltage, output_voltage, output_voltage, current_limit};
    end
  end

  // Configuration writes; an index outside the list has no register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      output_voltage    <= OUTPUT_VOLTAGE_RESET;
      over_voltage      <= OVER_VOLTAGE_RESET;
      long_walk_in      <= LONG_WALK_IN_RESET;
      current_increment <= CURRENT_INCREMENT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OUTPUT_VOLTAGE:    output_voltage    <= cfg_data;
        REG_OVER_VOLTAGE:      over_voltage      <= cfg_data;
        REG_LONG_WALK_IN:      long_walk_in      <= cfg_data[0];
        REG_CURRENT_INCREMENT: current_increment <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Unit state and sequencing of the frame plan.
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_serial   <= '0;
      frame_count   <= '0;
      current_limit <= CURRENT_RESTART;
      busy          <= 1'b0;
      plan_idx      <= '0;
      plan_len      <= '0;
    end else if (accept) begin
      unit_serial   <= unit_serial_next;
      frame_count   <= frame_count_next;
      current_limit <= current_limit_next;
      plan_len      <= plan_len_next;
      plan_idx      <= '0;
      busy          <= (plan_len_next != 2'd0);
    end else if (push) begin
      plan_idx <= plan_idx + 2'd1;
      if (push_data.last) begin
        busy <= 1'b0;
      end
    end
  end

  // Plan kinds carry no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      plan <= plan_next;
    end
  end

  assign status.busy          = busy;
  assign status.push          = push;
  assign status.current_limit = current_limit;

endmodule

// ===== hdl/rclc_back.sv =====
// Back part: moves queued frames into the output register of the master side.
module rclc_back
  import rclc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  queue_status_t q_status,
  input  frame_t        q_data,
  output logic          pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [95:0]   m_tdata,
  output logic          m_tlast
);

  frame_t out_frame;

  // Load a new beat when the register is empty or its beat is taken.
  assign pop = !q_status.empty && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_frame <= q_data;
    end
  end

  assign m_tdata = {3'd0, out_frame.data, out_frame.id};
  assign m_tlast = out_frame.last;

endmodule

// ===== hdl/rectifier_can_login_controller_unit.sv =====
// Flow: an input beat is taken, then its 0 to 3 frames enter the queue one per cycle
// while the queue has room; the slave side is held until its last frame is queued.
// The first result beat passes the front plan, the queue and the output register
// before it is offered at the master side; the front sequencer sets the throughput.
// Reset (rst, synchronous, active high) clears queue, output valid, unit serial,
// message counter, sets the current limit to 100 and loads register defaults.
module rectifier_can_login_controller_unit
  import rclc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Slave side: tdata = frame_id[28:0], data0..data7 from bit 29 up, zero fill.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,
  // tuser = button_pressed.
  input  logic        s_tuser,
  // Master side: tdata = tx_id[28:0], tx0..tx7 from bit 29 up, zero fill.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,
  // tlast = last_frame.
  output logic        m_tlast,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  front_status_t f_status;
  queue_status_t q_status;
  logic          push;
  frame_t        push_data;
  logic          pop;
  frame_t        q_data;

  rclc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data),
    .status    (f_status)
  );

  rclc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (q_data),
    .status    (q_status)
  );

  rclc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .q_data   (q_data),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // The front never offers a frame to a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    f_status.push |-> !q_status.full)
    else $error("frame pushed into full queue");

  // The current limit always stays at or below the maximum.
  a_current_range: assert property (@(posedge clk) disable iff (rst)
    f_status.current_limit <= CURRENT_MAX)
    else $error("current limit above maximum");

  // A beat can only appear at the output if the queue held one.
  a_out_from_queue: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid && q_status.empty) |=> !m_tvalid)
    else $error("output beat without queued frame");

  // The slave side is held while the front still has frames to queue.
  a_ready_busy: assert property (@(posedge clk) disable iff (rst)
    f_status.busy |-> !s_tready)
    else $error("input taken while front busy");

endmodule
